FILE: rtl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; every other file in rtl/ refers to this package.
package cbm_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned MemAddrW = 21;

  // Target codes of a result beat.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;

  // Cartridge kinds held in the configuration register.
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_BANKED = 2'd1;

  // Register windows below 0x8000, selected by address bits 14:13.
  localparam logic [1:0] REG_RAM_EN   = 2'd0;
  localparam logic [1:0] REG_LOW_BANK = 2'd1;
  localparam logic [1:0] REG_UPPER    = 2'd2;
  localparam logic [1:0] REG_MODE     = 2'd3;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [DataW-1:0] OPEN_BUS = 8'hFF;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] bus_address;
    logic [DataW-1:0] bus_data;
  } req_t;

  typedef struct packed {
    logic [1:0]          target;
    logic [MemAddrW-1:0] mem_address;
    logic                mem_write;
    logic [DataW-1:0]    mem_data;
  } resp_t;

  typedef struct packed {
    logic [4:0] low_bank;
    logic [1:0] upper_bits;
    logic       bank_mode;
    logic       ram_enable;
  } bank_t;

  localparam bank_t BANK_RESET = '{low_bank: 5'd1, upper_bits: 2'd0,
                                   bank_mode: 1'b0, ram_enable: 1'b0};

endpackage

FILE: rtl/cbm_channels.sv
// Valid/ready channel interfaces for bus accesses, mapped results and configuration.
// Depends on cbm_pkg for field widths.
interface cbm_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [cbm_pkg::AddrW-1:0]  bus_address;
  logic [cbm_pkg::DataW-1:0]  bus_data;

  modport source (output valid, action, bus_address, bus_data, input ready);
  modport sink   (input valid, action, bus_address, bus_data, output ready);
endinterface

interface cbm_resp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   target;
  logic [cbm_pkg::MemAddrW-1:0] mem_address;
  logic                         mem_write;
  logic [cbm_pkg::DataW-1:0]    mem_data;

  modport source (output valid, target, mem_address, mem_write, mem_data, input ready);
  modport sink   (input valid, target, mem_address, mem_write, mem_data, output ready);
endinterface

interface cbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] cart_kind;

  modport source (output valid, cart_kind, input ready);
  modport sink   (input valid, cart_kind, output ready);
endinterface

FILE: rtl/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: input register, decode, result register, bank state.
// Depends on cbm_pkg, the channel interfaces in cbm_channels.sv and cbm_decode.
//
//   channel | modport | beat carries
//   --------+---------+------------------------------------------------
//   req     | sink    | action, bus_address, bus_data
//   resp    | source  | target, mem_address, mem_write, mem_data
//   cfg     | sink    | cart_kind (always ready)
//
// One access per clock while resp does not stall. A beat is captured in the input
// register, decoded combinationally and then registered in the output register.
// Bank registers change as a write leaves the input register, so the following
// access already sees the new banks. rst is synchronous and restores the bank
// reset values and a plain cartridge kind. A stall on resp holds both stages
// and drops req.ready only when the input register is full.
module cartridge_bank_mapper (
  input  logic         clk,
  input  logic         rst,
  cbm_req_if.sink      req,
  cbm_resp_if.source   resp,
  cbm_cfg_if.sink      cfg
);

  logic           s1_valid;
  cbm_pkg::req_t  s1_req;
  logic           out_valid;
  cbm_pkg::resp_t out_resp;
  cbm_pkg::resp_t dec_resp;
  cbm_pkg::bank_t bank;
  cbm_pkg::bank_t bank_next;
  logic [1:0]     cart_kind;
  logic           advance;

  assign advance   = !out_valid || resp.ready;
  assign req.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  cbm_decode u_decode (
    .req       (s1_req),
    .bank      (bank),
    .cart_kind (cart_kind),
    .resp      (dec_resp),
    .bank_next (bank_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      bank      <= cbm_pkg::BANK_RESET;
      cart_kind <= cbm_pkg::KIND_PLAIN;
    end else begin
      if (cfg.valid) begin
        cart_kind <= cfg.cart_kind;
      end
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          bank <= bank_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req.action      <= req.action;
      s1_req.bus_address <= req.bus_address;
      s1_req.bus_data    <= req.bus_data;
    end
    if (advance && s1_valid) begin
      out_resp <= dec_resp;
    end
  end

  assign resp.valid       = out_valid;
  assign resp.target      = out_resp.target;
  assign resp.mem_address = out_resp.mem_address;
  assign resp.mem_write   = out_resp.mem_write;
  assign resp.mem_data    = out_resp.mem_data;

  a_low_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    bank.low_bank != 5'd0)
    else $error("low bank register holds zero");

  a_write_goes_to_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_resp.mem_write |-> out_resp.target == cbm_pkg::TGT_RAM)
    else $error("memory write on a beat that does not target RAM");

  a_none_has_no_address: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_resp.target == cbm_pkg::TGT_NONE |-> out_resp.mem_address == '0)
    else $error("unmapped beat carries a nonzero address");

  a_bank_only_on_beat: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && advance) |=> $stable(bank))
    else $error("bank registers changed without a beat leaving the input stage");

endmodule

FILE: rtl/cbm_decode.sv
// Combinational decode of one bus access: target, physical address and bank register update.
// Depends on cbm_pkg.
module cbm_decode (
  input  cbm_pkg::req_t  req,
  input  cbm_pkg::bank_t bank,
  input  logic [1:0]     cart_kind,
  output cbm_pkg::resp_t resp,
  output cbm_pkg::bank_t bank_next
);

  logic                             in_ram;
  logic                             in_rom;
  logic                             in_rom_low;
  logic [cbm_pkg::MemAddrW-1:0]     plain_ram_addr;
  logic [cbm_pkg::MemAddrW-1:0]     banked_ram_addr;
  logic [1:0]                       ram_page;
  logic [1:0]                       rom0_upper;

  assign in_ram     = (req.bus_address[15:13] == 3'b101);
  assign in_rom     = !req.bus_address[15];
  assign in_rom_low = (req.bus_address[15:14] == 2'b00);
  assign ram_page   = bank.bank_mode ? bank.upper_bits : 2'd0;
  assign rom0_upper = bank.bank_mode ? bank.upper_bits : 2'd0;

  // Inside 0xA000-0xBFFF the offset from 0xA000 is just the low 13 bits.
  assign plain_ram_addr  = {8'd0, req.bus_address[12:0]};
  assign banked_ram_addr = {6'd0, ram_page, req.bus_address[12:0]};

  always_comb begin
    resp      = '0;
    bank_next = bank;
    case (cart_kind)
      cbm_pkg::KIND_PLAIN: begin
        if (req.action) begin
          if (in_ram) begin
            resp.target      = cbm_pkg::TGT_RAM;
            resp.mem_address = plain_ram_addr;
            resp.mem_write   = 1'b1;
            resp.mem_data    = req.bus_data;
          end
        end else if (in_rom) begin
          resp.target      = cbm_pkg::TGT_ROM;
          resp.mem_address = {5'd0, req.bus_address};
        end else if (in_ram) begin
          resp.target      = cbm_pkg::TGT_RAM;
          resp.mem_address = plain_ram_addr;
        end else begin
          resp.mem_data = cbm_pkg::OPEN_BUS;
        end
      end
      cbm_pkg::KIND_BANKED: begin
        if (req.action) begin
          if (in_rom) begin
            unique case (req.bus_address[14:13])
              cbm_pkg::REG_RAM_EN:
                bank_next.ram_enable = (req.bus_data[3:0] == cbm_pkg::RAM_EN_KEY);
              cbm_pkg::REG_LOW_BANK:
                bank_next.low_bank = (req.bus_data[4:0] == 5'd0) ? 5'd1 : req.bus_data[4:0];
              cbm_pkg::REG_UPPER:
                bank_next.upper_bits = req.bus_data[1:0];
              cbm_pkg::REG_MODE:
                bank_next.bank_mode = req.bus_data[0];
              default: bank_next = bank;
            endcase
          end else if (in_ram && bank.ram_enable) begin
            resp.target      = cbm_pkg::TGT_RAM;
            resp.mem_address = banked_ram_addr;
            resp.mem_write   = 1'b1;
            resp.mem_data    = req.bus_data;
          end
        end else if (in_rom_low) begin
          resp.target      = cbm_pkg::TGT_ROM;
          resp.mem_address = {rom0_upper, 5'd0, req.bus_address[13:0]};
        end else if (in_rom) begin
          resp.target      = cbm_pkg::TGT_ROM;
          resp.mem_address = {bank.upper_bits, bank.low_bank, req.bus_address[13:0]};
        end else if (in_ram && bank.ram_enable) begin
          resp.target      = cbm_pkg::TGT_RAM;
          resp.mem_address = banked_ram_addr;
        end else begin
          resp.mem_data = cbm_pkg::OPEN_BUS;
        end
      end
      default: begin
        // Unsupported cartridge: nothing is mapped, reads float high.
        resp.mem_data = req.action ? '0 : cbm_pkg::OPEN_BUS;
      end
    endcase
  end

endmodule
